### rtl/udprr_pkg.sv
package udprr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam int MIN_FRAME_BYTES     = 42;
    localparam logic [7:0] REPLY_TTL   = 8'd255;

    // Word count field wide enough for the largest allowed frame limit.
    localparam int WORD_CNT_W  = 14;
    localparam int BYTE_CNT_W  = WORD_CNT_W + 1;
    localparam int QUEUE_DEPTH = 2;

    // Word positions within the frame.
    localparam int IDX_MAC_A0    = 0;
    localparam int IDX_MAC_A2    = 2;
    localparam int IDX_MAC_B0    = 3;
    localparam int IDX_MAC_B2    = 5;
    localparam int IDX_VER_TOS   = 7;
    localparam int IDX_PROTO     = 11;
    localparam int IDX_IP_A0     = 13;
    localparam int IDX_IP_A1     = 14;
    localparam int IDX_IP_B0     = 15;
    localparam int IDX_IP_B1     = 16;
    localparam int IDX_PORT_A    = 17;
    localparam int IDX_PORT_B    = 18;
    localparam int IDX_PAYLOAD   = 21;

    typedef struct packed {
        logic [15:0] frame_word;
        logic        is_last;
        logic        odd_tail;
    } frame_word_t;

    typedef struct packed {
        logic [47:0] reply_dst_mac;
        logic [47:0] reply_src_mac;
        logic [31:0] reply_src_ip;
        logic [31:0] reply_dst_ip;
        logic [15:0] reply_src_port;
        logic [15:0] reply_dst_port;
        logic [10:0] ip_total_length;
        logic [15:0] ip_header_checksum;
        logic [10:0] udp_length;
        logic [15:0] udp_checksum;
        logic        frame_error;
    } reply_t;

    typedef struct packed {
        logic [47:0]           first_mac;
        logic [47:0]           second_mac;
        logic [15:0]           version_tos_word;
        logic [7:0]            protocol_byte;
        logic [31:0]           first_ip;
        logic [31:0]           second_ip;
        logic [15:0]           first_port;
        logic [15:0]           second_port;
        logic [31:0]           payload_sum;
        logic [WORD_CNT_W-1:0] word_count;
        logic                  odd_tail;
    } frame_rec_t;

endpackage

### rtl/udprr_front.sv
module udprr_front
    import udprr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  frame_word_t frame,
    output logic        rec_push,
    output frame_rec_t  rec
);

    localparam int WORD_CAP = MAX_FRAME_BYTES / 2 + 1;
    localparam int IDX_W    = $clog2(WORD_CAP + 1);

    logic [IDX_W-1:0] word_index_reg, word_index_next;
    logic [47:0]      first_mac_reg, first_mac_next;
    logic [47:0]      second_mac_reg, second_mac_next;
    logic [15:0]      version_tos_reg, version_tos_next;
    logic [7:0]       protocol_reg, protocol_next;
    logic [31:0]      first_ip_reg, first_ip_next;
    logic [31:0]      second_ip_reg, second_ip_next;
    logic [15:0]      first_port_reg, first_port_next;
    logic [15:0]      second_port_reg, second_port_next;
    logic [31:0]      payload_sum_reg, payload_sum_next;
    logic [15:0]      w;
    logic             last;

    assign last = frame.is_last;

    always_comb
    begin
        w = frame.frame_word;
        if (last && frame.odd_tail)
        begin
            w = {frame.frame_word[15:8], 8'h00};
        end

        first_mac_next   = first_mac_reg;
        second_mac_next  = second_mac_reg;
        version_tos_next = version_tos_reg;
        protocol_next    = protocol_reg;
        first_ip_next    = first_ip_reg;
        second_ip_next   = second_ip_reg;
        first_port_next  = first_port_reg;
        second_port_next = second_port_reg;
        payload_sum_next = payload_sum_reg;

        case (int'(word_index_reg)) inside
            [IDX_MAC_A0:IDX_MAC_A2]: first_mac_next = {first_mac_reg[31:0], w};
            [IDX_MAC_B0:IDX_MAC_B2]: second_mac_next = {second_mac_reg[31:0], w};
            IDX_VER_TOS:             version_tos_next = w;
            IDX_PROTO:               protocol_next = w[7:0];
            IDX_IP_A0, IDX_IP_A1:    first_ip_next = {first_ip_reg[15:0], w};
            IDX_IP_B0, IDX_IP_B1:    second_ip_next = {second_ip_reg[15:0], w};
            IDX_PORT_A:              first_port_next = w;
            IDX_PORT_B:              second_port_next = w;
            default:
            begin
                if (int'(word_index_reg) >= IDX_PAYLOAD && int'(word_index_reg) < WORD_CAP)
                begin
                    payload_sum_next = payload_sum_reg + 32'(w);
                end
            end
        endcase

        if (last)
        begin
            word_index_next = '0;
        end
        else if (int'(word_index_reg) < WORD_CAP)
        begin
            word_index_next = word_index_reg + IDX_W'(1);
        end
        else
        begin
            word_index_next = word_index_reg;
        end
    end

    always_comb
    begin
        rec.first_mac        = first_mac_next;
        rec.second_mac       = second_mac_next;
        rec.version_tos_word = version_tos_next;
        rec.protocol_byte    = protocol_next;
        rec.first_ip         = first_ip_next;
        rec.second_ip        = second_ip_next;
        rec.first_port       = first_port_next;
        rec.second_port      = second_port_next;
        rec.payload_sum      = payload_sum_next;
        rec.word_count       = WORD_CNT_W'(word_index_reg) + WORD_CNT_W'(1);
        rec.odd_tail         = frame.odd_tail;
    end

    assign rec_push = take && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_index_reg  <= '0;
            first_mac_reg   <= '0;
            second_mac_reg  <= '0;
            version_tos_reg <= '0;
            protocol_reg    <= '0;
            first_ip_reg    <= '0;
            second_ip_reg   <= '0;
            first_port_reg  <= '0;
            second_port_reg <= '0;
            payload_sum_reg <= '0;
        end
        else if (take)
        begin
            word_index_reg <= word_index_next;
            if (last)
            begin
                first_mac_reg   <= '0;
                second_mac_reg  <= '0;
                version_tos_reg <= '0;
                protocol_reg    <= '0;
                first_ip_reg    <= '0;
                second_ip_reg   <= '0;
                first_port_reg  <= '0;
                second_port_reg <= '0;
                payload_sum_reg <= '0;
            end
            else
            begin
                first_mac_reg   <= first_mac_next;
                second_mac_reg  <= second_mac_next;
                version_tos_reg <= version_tos_next;
                protocol_reg    <= protocol_next;
                first_ip_reg    <= first_ip_next;
                second_ip_reg   <= second_ip_next;
                first_port_reg  <= first_port_next;
                second_port_reg <= second_port_next;
                payload_sum_reg <= payload_sum_next;
            end
        end
    end

endmodule

### rtl/udprr_queue.sv
module udprr_queue
    import udprr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  frame_rec_t wr_data,
    output logic       q_full,
    input  logic       rd_en,
    output logic       q_empty,
    output frame_rec_t rd_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    frame_rec_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_full  = (int'(count_reg) == QUEUE_DEPTH);
    assign q_empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                     : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0
                                                                     : rd_ptr_reg + PTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/udprr_back.sv
module udprr_back
    import udprr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  frame_rec_t rec,
    output logic       rec_pop,
    output logic       empty,
    input  logic       pop,
    output reply_t     reply
);

    function automatic logic [15:0] fold16(input logic [32:0] s);
        logic [17:0] a;
        logic [16:0] b;
        logic [15:0] c;
        a = 18'(s[15:0]) + 18'(s[32:16]);
        b = 17'(a[15:0]) + 17'(a[17:16]);
        c = b[15:0] + 16'(b[16]);
        return c;
    endfunction

    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        s1_ready;
    logic        s2_ready;

    logic [47:0] s1_dst_mac_reg, s1_src_mac_reg;
    logic [31:0] s1_src_ip_reg, s1_dst_ip_reg;
    logic [15:0] s1_src_port_reg, s1_dst_port_reg;
    logic [10:0] s1_ip_len_reg, s1_udp_len_reg;
    logic [18:0] s1_ip_sum_reg;
    logic [32:0] s1_udp_sum_reg;
    logic        s1_err_reg;

    logic [BYTE_CNT_W-1:0] bytes;
    logic [BYTE_CNT_W-1:0] ip_len;
    logic [BYTE_CNT_W-1:0] udp_len;
    logic                  err;
    logic [18:0]           ip_sum;
    logic [32:0]           udp_sum;
    logic [15:0]           ip_ck;
    logic [15:0]           udp_ck;
    reply_t                reply_reg, reply_next;

    assign s2_ready = !s2_valid_reg || pop;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign rec_pop  = s1_ready && !q_empty;
    assign empty    = !s2_valid_reg;
    assign reply    = reply_reg;

    always_comb
    begin
        bytes   = {rec.word_count, 1'b0} - BYTE_CNT_W'(rec.odd_tail);
        err     = (int'(bytes) < MIN_FRAME_BYTES) || (int'(bytes) > MAX_FRAME_BYTES);
        ip_len  = bytes - BYTE_CNT_W'(14);
        udp_len = bytes - BYTE_CNT_W'(34);
        ip_sum  = 19'(rec.version_tos_word) + 19'(ip_len)
                + 19'({REPLY_TTL, rec.protocol_byte})
                + 19'(rec.first_ip[31:16]) + 19'(rec.first_ip[15:0])
                + 19'(rec.second_ip[31:16]) + 19'(rec.second_ip[15:0]);
        udp_sum = 33'(rec.first_ip[31:16]) + 33'(rec.first_ip[15:0])
                + 33'(rec.second_ip[31:16]) + 33'(rec.second_ip[15:0])
                + 33'(rec.protocol_byte) + 33'({udp_len, 1'b0})
                + 33'(rec.first_port) + 33'(rec.second_port)
                + 33'(rec.payload_sum);
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            s1_dst_mac_reg  <= rec.second_mac;
            s1_src_mac_reg  <= rec.first_mac;
            s1_src_ip_reg   <= rec.second_ip;
            s1_dst_ip_reg   <= rec.first_ip;
            s1_src_port_reg <= rec.second_port;
            s1_dst_port_reg <= rec.first_port;
            s1_ip_len_reg   <= err ? 11'd0 : ip_len[10:0];
            s1_udp_len_reg  <= err ? 11'd0 : udp_len[10:0];
            s1_ip_sum_reg   <= ip_sum;
            s1_udp_sum_reg  <= udp_sum;
            s1_err_reg      <= err;
        end
    end

    always_comb
    begin
        ip_ck  = ~fold16(33'(s1_ip_sum_reg));
        udp_ck = ~fold16(s1_udp_sum_reg);
        if (udp_ck == 16'h0000)
        begin
            udp_ck = 16'hFFFF;
        end

        reply_next.reply_dst_mac      = s1_dst_mac_reg;
        reply_next.reply_src_mac      = s1_src_mac_reg;
        reply_next.reply_src_ip       = s1_src_ip_reg;
        reply_next.reply_dst_ip       = s1_dst_ip_reg;
        reply_next.reply_src_port     = s1_src_port_reg;
        reply_next.reply_dst_port     = s1_dst_port_reg;
        reply_next.ip_total_length    = s1_ip_len_reg;
        reply_next.ip_header_checksum = s1_err_reg ? 16'h0000 : ip_ck;
        reply_next.udp_length         = s1_udp_len_reg;
        reply_next.udp_checksum       = s1_err_reg ? 16'h0000 : udp_ck;
        reply_next.frame_error        = s1_err_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            reply_reg <= reply_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= !q_empty;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

endmodule

### rtl/udp_reply_header_rewrite.sv
// Builds the reply header for an Ethernet/IPv4/UDP frame that streams in as
// big-endian 16-bit words, one word per push, first byte in the high half.
// The input side is a queue: a word is taken when push is high and full is
// low. The word with is_last set closes the frame and yields one reply word
// with swapped addresses and ports, new lengths and both checksums.
// The output side is a queue too: the oldest reply is on reply while empty
// is low, and it is taken when pop is high.
// Input throughput is one word per cycle, and back-to-back frames of any
// length, even one word each, run at that rate while pop is kept high.
// After its last word is taken, a reply passes the record queue, the checksum
// stage registers and then the output register, which holds the final
// checksum fold.
// When pop stays low, up to two finished frames wait in the record queue and
// two in the back pipeline; after that full rises and holds the input off.
// Reset clears the frame capture state, the queue and the pipeline, so the
// next word taken is treated as the first word of a new frame.
module udp_reply_header_rewrite
    import udprr_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  frame_word_t frame,
    output logic        empty,
    input  logic        pop,
    output reply_t      reply
);

    logic       take;
    logic       rec_push;
    logic       rec_pop;
    logic       q_full;
    logic       q_empty;
    frame_rec_t rec_in;
    frame_rec_t rec_out;

    assign full = q_full;
    assign take = push && !q_full;

    udprr_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .frame    (frame),
        .rec_push (rec_push),
        .rec      (rec_in)
    );

    udprr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_in),
        .q_full  (q_full),
        .rd_en   (rec_pop),
        .q_empty (q_empty),
        .rd_data (rec_out)
    );

    udprr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .rec     (rec_out),
        .rec_pop (rec_pop),
        .empty   (empty),
        .pop     (pop),
        .reply   (reply)
    );

endmodule

### rtl/udprr_checker.sv
module udprr_checker
    import udprr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input reply_t      reply
);

    // Nothing is waiting right after reset.
    assert property (@(posedge clk) !rst_n |=> empty)
        else $error("reply queue not empty after reset");

    // A stalled reply word holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(reply)))
        else $error("stalled reply word changed");

    // The IP and UDP lengths differ by the 20-byte IP header.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !reply.frame_error) |->
            (reply.ip_total_length == reply.udp_length + 11'd20))
        else $error("IP and UDP lengths disagree");

    // A flagged frame carries zero lengths and zero checksums.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && reply.frame_error) |->
            (reply.ip_total_length == 11'd0 && reply.udp_length == 11'd0 &&
             reply.ip_header_checksum == 16'h0000 && reply.udp_checksum == 16'h0000))
        else $error("flagged frame has nonzero lengths or checksums");

    // A good frame never sends a zero UDP checksum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !reply.frame_error) |-> (reply.udp_checksum != 16'h0000))
        else $error("zero UDP checksum on a good frame");

endmodule

bind udp_reply_header_rewrite udprr_checker u_checker (.*);

### verif/reply_header_checker.sv
`timescale 1ns / 1ps
module reply_header_checker
    import udprr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  frame_word_t frame,
    input  logic        empty,
    input  logic        pop,
    input  reply_t      reply,
    output int          mismatch_count,
    output int          waiting_count,
    output int          reply_count,
    output int          bad_length_count
);

    localparam int WORD_CAP    = MAX_FRAME_BYTES_DEF / 2 + 1;
    localparam int PRINT_LIMIT = 40;

    int          word_pos;
    logic [47:0] mac_a;
    logic [47:0] mac_b;
    logic [15:0] ver_tos;
    logic [7:0]  proto;
    logic [31:0] ip_a;
    logic [31:0] ip_b;
    logic [15:0] port_a;
    logic [15:0] port_b;
    logic [31:0] payload_total;
    reply_t      expected_replies[$];

    initial
    begin
        mismatch_count   = 0;
        waiting_count    = 0;
        reply_count      = 0;
        bad_length_count = 0;
    end

    function automatic logic [15:0] fold_ones(input logic [63:0] s);
        while (s > 64'hFFFF)
            s = {48'd0, s[15:0]} + (s >> 16);
        return s[15:0];
    endfunction

    task automatic clear_capture();
        word_pos      = 0;
        mac_a         = '0;
        mac_b         = '0;
        ver_tos       = '0;
        proto         = '0;
        ip_a          = '0;
        ip_b          = '0;
        port_a        = '0;
        port_b        = '0;
        payload_total = '0;
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] MISMATCH on reply %0d: %s", $time, reply_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
    endtask

    task automatic absorb_word(input frame_word_t fw);
        logic [15:0] w;
        int          nbytes;
        bit          bad;
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [15:0] ip_ck;
        logic [15:0] udp_ck;
        logic [63:0] acc;
        reply_t      hdr;
        w = fw.frame_word;
        if (fw.is_last && fw.odd_tail)
            w[7:0] = 8'h00;
        case (word_pos)
            IDX_MAC_A0, IDX_MAC_A0 + 1, IDX_MAC_A2: mac_a = {mac_a[31:0], w};
            IDX_MAC_B0, IDX_MAC_B0 + 1, IDX_MAC_B2: mac_b = {mac_b[31:0], w};
            IDX_VER_TOS: ver_tos = w;
            IDX_PROTO: proto = w[7:0];
            IDX_IP_A0, IDX_IP_A1: ip_a = {ip_a[15:0], w};
            IDX_IP_B0, IDX_IP_B1: ip_b = {ip_b[15:0], w};
            IDX_PORT_A: port_a = w;
            IDX_PORT_B: port_b = w;
            default:
            begin
                if (word_pos >= IDX_PAYLOAD && word_pos < WORD_CAP)
                    payload_total += 32'(w);
            end
        endcase
        if (!fw.is_last)
        begin
            if (word_pos < WORD_CAP)
                word_pos++;
            return;
        end
        nbytes  = 2 * (word_pos + 1) - int'(fw.odd_tail);
        bad     = nbytes < MIN_FRAME_BYTES || nbytes > MAX_FRAME_BYTES_DEF;
        ip_len  = '0;
        udp_len = '0;
        ip_ck   = '0;
        udp_ck  = '0;
        if (!bad)
        begin
            ip_len  = 16'(nbytes - 14);
            udp_len = 16'(nbytes - 34);
            acc = 64'(ver_tos) + 64'(ip_len) + 64'({REPLY_TTL, proto})
                + 64'(ip_a[31:16]) + 64'(ip_a[15:0])
                + 64'(ip_b[31:16]) + 64'(ip_b[15:0]);
            ip_ck = ~fold_ones(acc);
            acc = 64'(ip_a[31:16]) + 64'(ip_a[15:0])
                + 64'(ip_b[31:16]) + 64'(ip_b[15:0])
                + 64'(proto) + (64'(udp_len) << 1)
                + 64'(port_a) + 64'(port_b) + 64'(payload_total);
            udp_ck = ~fold_ones(acc);
            if (udp_ck == 16'h0000)
                udp_ck = 16'hFFFF;
        end
        hdr.reply_dst_mac      = mac_b;
        hdr.reply_src_mac      = mac_a;
        hdr.reply_src_ip       = ip_b;
        hdr.reply_dst_ip       = ip_a;
        hdr.reply_src_port     = port_b;
        hdr.reply_dst_port     = port_a;
        hdr.ip_total_length    = ip_len[10:0];
        hdr.ip_header_checksum = ip_ck;
        hdr.udp_length         = udp_len[10:0];
        hdr.udp_checksum       = udp_ck;
        hdr.frame_error        = bad;
        if (bad)
            bad_length_count++;
        expected_replies.push_back(hdr);
        clear_capture();
    endtask

    task automatic check_reply(input reply_t got);
        reply_t want;
        if (expected_replies.size() == 0)
        begin
            report_mismatch($sformatf("reply %h arrived with none outstanding", got));
            return;
        end
        want = expected_replies.pop_front();
        check_field("reply_dst_mac", 64'(got.reply_dst_mac), 64'(want.reply_dst_mac));
        check_field("reply_src_mac", 64'(got.reply_src_mac), 64'(want.reply_src_mac));
        check_field("reply_src_ip", 64'(got.reply_src_ip), 64'(want.reply_src_ip));
        check_field("reply_dst_ip", 64'(got.reply_dst_ip), 64'(want.reply_dst_ip));
        check_field("reply_src_port", 64'(got.reply_src_port),
                    64'(want.reply_src_port));
        check_field("reply_dst_port", 64'(got.reply_dst_port),
                    64'(want.reply_dst_port));
        check_field("ip_total_length", 64'(got.ip_total_length),
                    64'(want.ip_total_length));
        check_field("ip_header_checksum", 64'(got.ip_header_checksum),
                    64'(want.ip_header_checksum));
        check_field("udp_length", 64'(got.udp_length), 64'(want.udp_length));
        check_field("udp_checksum", 64'(got.udp_checksum), 64'(want.udp_checksum));
        check_field("frame_error", 64'(got.frame_error), 64'(want.frame_error));
        reply_count++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            clear_capture();
        else
        begin
            if (pop && !empty)
                check_reply(reply);
            if (push && !full)
                absorb_word(frame);
        end
        waiting_count = expected_replies.size();
    end

endmodule

### verif/tb_udp_reply_header_rewrite.sv
`timescale 1ns / 1ps
module tb_udp_reply_header_rewrite;
    import udprr_pkg::*;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_e;

    localparam int QUIET_LIMIT = 4000;
    localparam int IDLE_PCT    = 38;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        push  = 1'b0;
    logic        pop   = 1'b0;
    frame_word_t frame = '0;
    logic        full;
    logic        empty;
    reply_t      reply;

    int          mismatches;
    int          waiting;
    int          replies;
    int          bad_lengths;
    bit          calm         = 1'b0;
    int          words_sent   = 0;
    int          frames_sent  = 0;
    int          quiet_cycles = 0;
    logic [15:0] frame_buf[$];

    always #2 clk = ~clk;

    udp_reply_header_rewrite uut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .frame (frame),
        .empty (empty),
        .pop   (pop),
        .reply (reply)
    );

    reply_header_checker chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .frame            (frame),
        .empty            (empty),
        .pop              (pop),
        .reply            (reply),
        .mismatch_count   (mismatches),
        .waiting_count    (waiting),
        .reply_count      (replies),
        .bad_length_count (bad_lengths)
    );

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [15:0] w, input bit last, input bit odd);
        frame_word_t fw;
        fw.frame_word = w;
        fw.is_last    = last;
        fw.odd_tail   = last ? odd : 1'($urandom_range(1));
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push  <= 1'b1;
        frame <= fw;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_frame(input bit odd);
        for (int i = 0; i < frame_buf.size(); i++)
            send_word(frame_buf[i], i == frame_buf.size() - 1, odd);
        frames_sent++;
    endtask

    task automatic play_frame(input int nbytes, input fill_kind_e kind);
        frame_buf.delete();
        for (int i = 0; i < (nbytes + 1) / 2; i++)
        begin
            case (kind)
                FILL_ZERO: frame_buf.push_back(16'h0000);
                FILL_ONES: frame_buf.push_back(16'hFFFF);
                default:   frame_buf.push_back(16'($urandom_range(65535)));
            endcase
        end
        send_frame(1'(nbytes % 2));
    endtask

    task automatic drain_replies();
        push <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int         pick;
        int         nbytes;
        fill_kind_e kind;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        play_frame(1, FILL_ONES);
        play_frame(2, FILL_RANDOM);
        play_frame(30, FILL_RANDOM);
        play_frame(41, FILL_RANDOM);
        play_frame(42, FILL_RANDOM);
        play_frame(43, FILL_ONES);
        play_frame(42, FILL_ZERO);
        play_frame(42, FILL_ONES);
        play_frame(60, FILL_ONES);
        // All other words are zero, so the UDP sum folds to all ones and
        // its complement comes out as zero.
        frame_buf.delete();
        for (int i = 0; i < 22; i++)
            frame_buf.push_back(16'h0000);
        frame_buf[IDX_PAYLOAD] = 16'hFFEB;
        send_frame(1'b0);
        drain_replies();

        for (int f = 0; f < 16 || words_sent < 850; f++)
        begin
            calm = (f >= 4 && f < 10);
            if (f == 11)
                drain_replies();
            pick = $urandom_range(99);
            if (pick < 70)
                nbytes = $urandom_range(100, MIN_FRAME_BYTES);
            else if (pick < 85)
                nbytes = $urandom_range(MIN_FRAME_BYTES - 1, 1);
            else
                nbytes = $urandom_range(240, 101);
            kind = ($urandom_range(19) == 0) ? FILL_ONES : FILL_RANDOM;
            play_frame(nbytes, kind);
        end
        calm = 1'b0;

        drain_replies();
        repeat (8) @(negedge clk);
        $display("Pushed %0d frames in %0d words, from one byte up to a few hundred bytes.",
                 frames_sent, words_sent);
        $display("Checked %0d reply headers, %0d of them flagged for bad length.",
                 replies, bad_lengths);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/udprr_pkg.sv
rtl/udprr_front.sv
rtl/udprr_queue.sv
rtl/udprr_back.sv
rtl/udp_reply_header_rewrite.sv
rtl/udprr_checker.sv
verif/reply_header_checker.sv
verif/tb_udp_reply_header_rewrite.sv
